// File: src/iq_envelope_soft_limiter_top_assert.svh
// Assertion macros used by the checker file.
`ifndef IQ_ENVELOPE_SOFT_LIMITER_TOP_ASSERT_SVH
`define IQ_ENVELOPE_SOFT_LIMITER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled in reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/ivsl_pkg.sv
package ivsl_pkg;

    // Width of the overshoot gain register.
    localparam int GAIN_W = 4;

    // Width of the configuration register index.
    localparam int CFG_IDX_W = 1;

    // Register reset values.
    localparam int unsigned LIMIT_RESET = 5910;
    localparam int unsigned GAIN_RESET = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LIMIT = 1'b0,
        REG_GAIN  = 1'b1
    } cfg_reg_t;

    // Control handed to each cell of a chain.
    typedef struct packed {
        logic en;
        logic valid;
    } stage_ctl_t;

endpackage

// File: src/iq_envelope_soft_limiter_top.sv
// Channel   | Handshake              | Payload
// ----------+------------------------+-----------------------------------
// config    | cfg_we                 | cfg_index, cfg_data
// sample in | in_valid / in_stall    | in_i, in_q
// result    | out_valid / out_stall  | out_i, out_q, envelope
//
// One sample is accepted per cycle while in_stall is low; each result passes through
// the front, envelope and rescale stages, the chains of square-root and divider cells and the output register.
// Reset is asynchronous and active low; it restores both registers and empties
// the pipeline. A stalled result waits in the output register while a spare
// register takes one more beat; in_stall rises only when that spare is full.
module iq_envelope_soft_limiter_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ivsl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [SAMPLE_BITS-2:0]              cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic signed [SAMPLE_BITS-1:0]       in_i,
    input  logic signed [SAMPLE_BITS-1:0]       in_q,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [SAMPLE_BITS-1:0]       out_i,
    output logic signed [SAMPLE_BITS-1:0]       out_q,
    output logic [SAMPLE_BITS-1:0]              envelope
);

    localparam int W = SAMPLE_BITS;
    localparam int LW = W - 1;
    localparam int GW = ivsl_pkg::GAIN_W;
    localparam int DW = W + GW + 1;
    localparam int NW = 2 * W - 1;
    localparam int RW = 2 * W;
    localparam int SW1 = 2 * W + 2;
    localparam int SW2 = W + 2;
    localparam int SW3 = W + 4;
    localparam logic [W-1:0] FS_W = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MIN_W = {1'b1, {(W-1){1'b0}}};

    // Configuration registers.
    logic [LW-1:0] limit_reg;
    logic [GW-1:0] gain_reg;
    logic [LW-1:0] limit_eff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LW'(ivsl_pkg::LIMIT_RESET);
            gain_reg <= GW'(ivsl_pkg::GAIN_RESET);
        end
        else if (cfg_we)
        begin
            unique case (ivsl_pkg::cfg_reg_t'(cfg_index))
                ivsl_pkg::REG_LIMIT: limit_reg <= cfg_data;
                ivsl_pkg::REG_GAIN:  gain_reg <= cfg_data[GW-1:0];
                default: ;
            endcase
        end
    end

    // A limit of zero acts as one.
    assign limit_eff = (limit_reg == '0) ? LW'(1) : limit_reg;

    // Pipeline advance and input handshake.
    logic spare_valid_reg;
    logic en;
    logic accept;

    assign en = !spare_valid_reg;
    assign in_stall = spare_valid_reg;
    assign accept = in_valid && !spare_valid_reg;

    // Front stages: capture, magnitude, squares, sum.
    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic signed [W-1:0] i0_reg, q0_reg;
    logic sgn_i1_reg, sgn_q1_reg, sgn_i2_reg, sgn_q2_reg, sgn_i3_reg, sgn_q3_reg;
    logic [W-1:0] mag_i1_reg, mag_q1_reg, mag_i2_reg, mag_q2_reg;
    logic [W-1:0] mag_i3_reg, mag_q3_reg;
    logic [RW-1:0] sq_i2_reg, sq_q2_reg, sum3_reg;

    // Envelope and divisor stages.
    logic ve1_reg, ve2_reg;
    logic sgn_ie1_reg, sgn_qe1_reg, sgn_ie2_reg, sgn_qe2_reg;
    logic [W-1:0] env_e1_reg, env_e2_reg, exc_e1_reg;
    logic [W-1:0] mag_ie1_reg, mag_qe1_reg;
    logic [DW-1:0] den_e2_reg;
    logic [NW-1:0] n1_i_e2_reg, n1_q_e2_reg;

    // Rescale stages.
    logic vf1_reg, vf2_reg;
    logic sgn_if1_reg, sgn_qf1_reg, sgn_if2_reg, sgn_qf2_reg;
    logic [W-1:0] env_f1_reg, env_f2_reg;
    logic [NW-1:0] n2_i_f1_reg, n2_q_f1_reg, n2_i_f2_reg, n2_q_f2_reg;
    logic ovf_i_f2_reg, ovf_q_f2_reg;

    // Valid bits along the chains of cells.
    logic sq_v [0:W];
    logic d1_v [0:W];
    logic d2_v [0:W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            ve1_reg <= 1'b0;
            ve2_reg <= 1'b0;
            vf1_reg <= 1'b0;
            vf2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            ve1_reg <= sq_v[W];
            ve2_reg <= ve1_reg;
            vf1_reg <= d1_v[W];
            vf2_reg <= vf1_reg;
        end
    end

    // Chain end points.
    logic [RW-1:0]  sq_rem  [0:W];
    logic [W-1:0]   sq_root [0:W];
    logic [SW1-1:0] sq_side [0:W];
    logic [NW-1:0]  d1_ra [0:W];
    logic [NW-1:0]  d1_rb [0:W];
    logic [DW-1:0]  d1_den [0:W];
    logic [W-1:0]   d1_qa [0:W];
    logic [W-1:0]   d1_qb [0:W];
    logic [SW2-1:0] d1_side [0:W];
    logic [NW-1:0]  d2_ra [0:W];
    logic [NW-1:0]  d2_rb [0:W];
    logic [DW-1:0]  d2_den [0:W];
    logic [W-1:0]   d2_qa [0:W];
    logic [W-1:0]   d2_qb [0:W];
    logic [SW3-1:0] d2_side [0:W];

    // Datapath registers of the plain stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (accept)
            begin
                i0_reg <= in_i;
                q0_reg <= in_q;
            end
            // Magnitudes; the most negative sample maps to 2^(W-1).
            sgn_i1_reg <= i0_reg[W-1];
            sgn_q1_reg <= q0_reg[W-1];
            mag_i1_reg <= i0_reg[W-1] ? (~i0_reg + W'(1)) : i0_reg;
            mag_q1_reg <= q0_reg[W-1] ? (~q0_reg + W'(1)) : q0_reg;
            // Squares.
            sgn_i2_reg <= sgn_i1_reg;
            sgn_q2_reg <= sgn_q1_reg;
            mag_i2_reg <= mag_i1_reg;
            mag_q2_reg <= mag_q1_reg;
            sq_i2_reg <= RW'(mag_i1_reg) * RW'(mag_i1_reg);
            sq_q2_reg <= RW'(mag_q1_reg) * RW'(mag_q1_reg);
            // Sum of squares.
            sgn_i3_reg <= sgn_i2_reg;
            sgn_q3_reg <= sgn_q2_reg;
            mag_i3_reg <= mag_i2_reg;
            mag_q3_reg <= mag_q2_reg;
            sum3_reg <= sq_i2_reg + sq_q2_reg;
            // Envelope against the limit.
            {sgn_ie1_reg, sgn_qe1_reg, mag_ie1_reg, mag_qe1_reg} <= sq_side[W];
            env_e1_reg <= sq_root[W];
            exc_e1_reg <= (sq_root[W] > W'(limit_eff)) ? (sq_root[W] - W'(limit_eff)) : '0;
            // Divisor and first numerators; no overshoot gives divisor = limit.
            sgn_ie2_reg <= sgn_ie1_reg;
            sgn_qe2_reg <= sgn_qe1_reg;
            env_e2_reg <= env_e1_reg;
            den_e2_reg <= DW'(exc_e1_reg) * DW'(gain_reg) + DW'(limit_eff);
            n1_i_e2_reg <= NW'(mag_ie1_reg) * NW'(limit_eff);
            n1_q_e2_reg <= NW'(mag_qe1_reg) * NW'(limit_eff);
            // Full-scale numerators.
            {sgn_if1_reg, sgn_qf1_reg, env_f1_reg} <= d1_side[W];
            n2_i_f1_reg <= NW'(d1_qa[W]) * NW'(FS_W);
            n2_q_f1_reg <= NW'(d1_qb[W]) * NW'(FS_W);
            // Quotients of 2^W or more saturate outright.
            sgn_if2_reg <= sgn_if1_reg;
            sgn_qf2_reg <= sgn_qf1_reg;
            env_f2_reg <= env_f1_reg;
            n2_i_f2_reg <= n2_i_f1_reg;
            n2_q_f2_reg <= n2_q_f1_reg;
            ovf_i_f2_reg <= RW'(n2_i_f1_reg) >= (RW'(limit_eff) << W);
            ovf_q_f2_reg <= RW'(n2_q_f1_reg) >= (RW'(limit_eff) << W);
        end
    end

    // Square-root chain, one root bit per cell.
    assign sq_v[0] = v3_reg;
    assign sq_rem[0] = sum3_reg;
    assign sq_root[0] = '0;
    assign sq_side[0] = {sgn_i3_reg, sgn_q3_reg, mag_i3_reg, mag_q3_reg};

    // First divider chain: soft limit.
    assign d1_v[0] = ve2_reg;
    assign d1_ra[0] = n1_i_e2_reg;
    assign d1_rb[0] = n1_q_e2_reg;
    assign d1_den[0] = den_e2_reg;
    assign d1_qa[0] = '0;
    assign d1_qb[0] = '0;
    assign d1_side[0] = {sgn_ie2_reg, sgn_qe2_reg, env_e2_reg};

    // Second divider chain: rescale to full scale.
    assign d2_v[0] = vf2_reg;
    assign d2_ra[0] = n2_i_f2_reg;
    assign d2_rb[0] = n2_q_f2_reg;
    assign d2_den[0] = DW'(limit_eff);
    assign d2_qa[0] = '0;
    assign d2_qb[0] = '0;
    assign d2_side[0] = {sgn_if2_reg, sgn_qf2_reg, ovf_i_f2_reg, ovf_q_f2_reg, env_f2_reg};

    genvar k;
    generate
        for (k = 0; k < W; k++)
        begin : g_chain
            ivsl_pkg::stage_ctl_t sq_ctl, d1_ctl, d2_ctl;

            assign sq_ctl = '{en: en, valid: sq_v[k]};
            assign d1_ctl = '{en: en, valid: d1_v[k]};
            assign d2_ctl = '{en: en, valid: d2_v[k]};

            ivsl_sqrt_cell #(
                .RW(RW), .QW(W), .B(W - 1 - k), .SIDE_W(SW1)
            ) u_sqrt (
                .clk(clk), .rst_n(rst_n), .ctl(sq_ctl),
                .rem_in(sq_rem[k]), .root_in(sq_root[k]), .side_in(sq_side[k]),
                .valid_out(sq_v[k+1]), .rem_out(sq_rem[k+1]),
                .root_out(sq_root[k+1]), .side_out(sq_side[k+1])
            );

            ivsl_div_cell #(
                .NW(NW), .DW(DW), .QW(W), .K(W - 1 - k), .SIDE_W(SW2)
            ) u_div1 (
                .clk(clk), .rst_n(rst_n), .ctl(d1_ctl),
                .rem_a_in(d1_ra[k]), .rem_b_in(d1_rb[k]), .den_in(d1_den[k]),
                .quo_a_in(d1_qa[k]), .quo_b_in(d1_qb[k]), .side_in(d1_side[k]),
                .valid_out(d1_v[k+1]), .rem_a_out(d1_ra[k+1]), .rem_b_out(d1_rb[k+1]),
                .den_out(d1_den[k+1]), .quo_a_out(d1_qa[k+1]), .quo_b_out(d1_qb[k+1]),
                .side_out(d1_side[k+1])
            );

            ivsl_div_cell #(
                .NW(NW), .DW(DW), .QW(W), .K(W - 1 - k), .SIDE_W(SW3)
            ) u_div2 (
                .clk(clk), .rst_n(rst_n), .ctl(d2_ctl),
                .rem_a_in(d2_ra[k]), .rem_b_in(d2_rb[k]), .den_in(d2_den[k]),
                .quo_a_in(d2_qa[k]), .quo_b_in(d2_qb[k]), .side_in(d2_side[k]),
                .valid_out(d2_v[k+1]), .rem_a_out(d2_ra[k+1]), .rem_b_out(d2_rb[k+1]),
                .den_out(d2_den[k+1]), .quo_a_out(d2_qa[k+1]), .quo_b_out(d2_qb[k+1]),
                .side_out(d2_side[k+1])
            );
        end
    endgenerate

    // Apply the sign and saturate a quotient magnitude.
    function automatic logic [W-1:0] sat_sample(input logic neg, input logic ovf,
                                                 input logic [W-1:0] mag);
        logic [W-1:0] res;
        if (!neg)
        begin
            res = (ovf || mag > FS_W) ? FS_W : mag;
        end
        else
        begin
            res = (ovf || mag > MIN_W) ? MIN_W : (~mag + W'(1));
        end
        return res;
    endfunction

    logic          pipe_valid;
    logic          push;
    logic          take;
    logic [W-1:0]  pipe_i, pipe_q, pipe_env;
    logic          p_sgn_i, p_sgn_q, p_ovf_i, p_ovf_q;

    // Output register with one spare beat.
    logic         out_valid_reg;
    logic [W-1:0] out_i_reg, out_q_reg, out_env_reg;
    logic [W-1:0] spare_i_reg, spare_q_reg, spare_env_reg;

    always_comb
    begin
        {p_sgn_i, p_sgn_q, p_ovf_i, p_ovf_q, pipe_env} = d2_side[W];
        pipe_i = sat_sample(p_sgn_i, p_ovf_i, d2_qa[W]);
        pipe_q = sat_sample(p_sgn_q, p_ovf_q, d2_qb[W]);
    end

    assign pipe_valid = d2_v[W];
    assign push = en && pipe_valid;
    assign take = out_valid_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            spare_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || take)
        begin
            if (spare_valid_reg)
            begin
                out_valid_reg <= 1'b1;
                spare_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            spare_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || take)
        begin
            if (spare_valid_reg)
            begin
                out_i_reg <= spare_i_reg;
                out_q_reg <= spare_q_reg;
                out_env_reg <= spare_env_reg;
            end
            else if (push)
            begin
                out_i_reg <= pipe_i;
                out_q_reg <= pipe_q;
                out_env_reg <= pipe_env;
            end
        end
        else if (push)
        begin
            spare_i_reg <= pipe_i;
            spare_q_reg <= pipe_q;
            spare_env_reg <= pipe_env;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_i = signed'(out_i_reg);
    assign out_q = signed'(out_q_reg);
    assign envelope = out_env_reg;

endmodule

// File: src/ivsl_sqrt_cell.sv
module ivsl_sqrt_cell #(
    parameter int RW = 32,
    parameter int QW = 16,
    parameter int B = 15,
    parameter int SIDE_W = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ivsl_pkg::stage_ctl_t ctl,
    input  logic [RW-1:0]        rem_in,
    input  logic [QW-1:0]        root_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic [RW-1:0]        rem_out,
    output logic [QW-1:0]        root_out,
    output logic [SIDE_W-1:0]    side_out
);

    logic [RW:0]     trial;
    logic            take;
    logic [RW-1:0]   rem_next;
    logic [QW-1:0]   root_next;
    logic            valid_reg;
    logic [RW-1:0]   rem_reg;
    logic [QW-1:0]   root_reg;
    logic [SIDE_W-1:0] side_reg;

    // Try setting root bit B: (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B).
    always_comb
    begin
        trial = ((RW+1)'(root_in) << (B + 1)) | ((RW+1)'(1) << (2 * B));
        take = (RW+1)'(rem_in) >= trial;
        rem_next = take ? RW'((RW+1)'(rem_in) - trial) : rem_in;
        root_next = take ? (root_in | (QW'(1) << B)) : root_in;
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    // Partial remainder and root move on with the chain.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_reg <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_out = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;

endmodule

// File: src/ivsl_div_cell.sv
module ivsl_div_cell #(
    parameter int NW = 31,
    parameter int DW = 21,
    parameter int QW = 16,
    parameter int K = 15,
    parameter int SIDE_W = 18
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ivsl_pkg::stage_ctl_t ctl,
    input  logic [NW-1:0]        rem_a_in,
    input  logic [NW-1:0]        rem_b_in,
    input  logic [DW-1:0]        den_in,
    input  logic [QW-1:0]        quo_a_in,
    input  logic [QW-1:0]        quo_b_in,
    input  logic [SIDE_W-1:0]    side_in,
    output logic                 valid_out,
    output logic [NW-1:0]        rem_a_out,
    output logic [NW-1:0]        rem_b_out,
    output logic [DW-1:0]        den_out,
    output logic [QW-1:0]        quo_a_out,
    output logic [QW-1:0]        quo_b_out,
    output logic [SIDE_W-1:0]    side_out
);

    localparam int XW = NW + DW;

    logic [XW-1:0]     dsh;
    logic              take_a;
    logic              take_b;
    logic              valid_reg;
    logic [NW-1:0]     rem_a_reg;
    logic [NW-1:0]     rem_b_reg;
    logic [DW-1:0]     den_reg;
    logic [QW-1:0]     quo_a_reg;
    logic [QW-1:0]     quo_b_reg;
    logic [SIDE_W-1:0] side_reg;

    // Restoring step for quotient bit K on both lanes.
    always_comb
    begin
        dsh = XW'(den_in) << K;
        take_a = XW'(rem_a_in) >= dsh;
        take_b = XW'(rem_b_in) >= dsh;
    end

    // Valid bit of this cell.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctl.en)
        begin
            valid_reg <= ctl.valid;
        end
    end

    // Remainders shrink and quotient bits shift in.
    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            rem_a_reg <= take_a ? NW'(XW'(rem_a_in) - dsh) : rem_a_in;
            rem_b_reg <= take_b ? NW'(XW'(rem_b_in) - dsh) : rem_b_in;
            quo_a_reg <= {quo_a_in[QW-2:0], take_a};
            quo_b_reg <= {quo_b_in[QW-2:0], take_b};
            den_reg <= den_in;
            side_reg <= side_in;
        end
    end

    assign valid_out = valid_reg;
    assign rem_a_out = rem_a_reg;
    assign rem_b_out = rem_b_reg;
    assign den_out = den_reg;
    assign quo_a_out = quo_a_reg;
    assign quo_b_out = quo_b_reg;
    assign side_out = side_reg;

endmodule

// File: src/ivsl_checker.sv
`include "iq_envelope_soft_limiter_top_assert.svh"

module ivsl_checker #(
    parameter int SAMPLE_BITS = 16
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_stall,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic signed [SAMPLE_BITS-1:0]  out_i,
    input logic signed [SAMPLE_BITS-1:0]  out_q,
    input logic [SAMPLE_BITS-1:0]         envelope
);

    // Input stalls only while a result beat is held at the output.
    `ASSERT_IMPLY(a_stall_needs_out, in_stall, out_valid)

    // Once the output beat is taken, the spare beat moves up and input reopens.
    `ASSERT_NEXT(a_stall_clears, in_stall && !out_stall, !in_stall)

    // A stalled result beat holds.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_i) && $stable(out_q) && $stable(envelope))

endmodule

bind iq_envelope_soft_limiter_top ivsl_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_ivsl_checker (.*);
